[rtl/mtt_pkg.sv]
// Shared types, codes and helpers for the timer table.
// Used by mtt_cell and multi_timer_table; depends on nothing else.
package mtt_pkg;

    localparam int SLOTS = 16;
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);

    localparam logic [30:0] WAIT_MAX = 31'h7FFF_FFFF;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_FIRE   = 3'd2;
    localparam logic [2:0] KIND_TICK   = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0]         id;
        logic [31:0]        expiry;
        logic [30:0]        period;
        logic signed [15:0] repeats;
    } t_entry;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  id;
        logic [1:0]  status;
        logic        finished;
        logic [30:0] next_wait;
        logic        last;
    } t_result;

    // Add with saturation at all ones
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [30:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {2'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

[rtl/multi_timer_table.sv]
// Timer table top level: request decode, scan sequencer and result register.
// Depends on mtt_pkg and mtt_cell.
//
// Requests enter on s_axis (tuser = operation, tdata = id, time, delay, period,
// repeat count). Results leave on m_axis (tuser = kind, tlast = final result
// of the request, tdata = id, status, finished, next wait).
// Entries live in a chain of 16 cells kept packed in insertion order. Remove
// and tick rotate the chain one entry per cycle, unless a tick holds as below,
// through the head cell, where the entry is checked, updated and written back
// to the tail or dropped. Add and clear act on acceptance, then the result is
// presented from the emit state; remove and tick scan each live entry first.
// One request is worked on at a time; s_axis_tready is high while idle,
// including while the last result still waits in the output register.
// When the receiver stalls, a tick scan holds at any entry that is due to fire
// until the output register frees; other entries keep moving.
// Reset empties the table and drops any pending result.
module multi_timer_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[1:0]
    input  logic [1:0]   s_axis_tuser,
    // timer_id[7:0], now_ms[39:8], first_delay[70:40], period[101:71],
    // repeat_count[117:102], zero[119:118]
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kind[2:0]
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    // fired_id[7:0], status[9:8], finished[10], next_wait[41:11], zero[47:42]
    output logic [47:0]  m_axis_tdata
);

    localparam int SLOTS = mtt_pkg::SLOTS;
    localparam int IW    = mtt_pkg::IW;
    localparam int CW    = mtt_pkg::CW;

    mtt_pkg::t_state r_state, n_state;
    logic [1:0]      r_op, n_op;
    logic [7:0]      r_id, n_id;
    logic [31:0]     r_now, n_now;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_left, n_left;
    logic            r_found, n_found;
    logic [30:0]     r_best, n_best;
    mtt_pkg::t_result r_res, n_res;
    logic            r_ovalid, n_ovalid;
    mtt_pkg::t_result r_out, n_out;

    mtt_pkg::t_entry w_cell [SLOTS];
    logic            w_load [SLOTS];
    mtt_pkg::t_entry w_load_data;
    logic            w_shift;
    logic [IW-1:0]   w_load_idx;
    logic            w_load_en;

    mtt_pkg::t_entry  w_head, w_upd, w_new;
    logic             w_hit, w_fin, w_out_free, w_accept;
    logic [31:0]      w_diff, w_wait;
    logic [CW-1:0]    w_tail;

    // Chain of cells, each fed by its right neighbor; the last cell feeds itself
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        if (g < SLOTS - 1) begin : g_mid
            mtt_cell u_cell (
                .i_clk       (i_clk),
                .i_load      (w_load[g]),
                .i_load_data (w_load_data),
                .i_shift     (w_shift),
                .i_neighbor  (w_cell[g+1]),
                .o_entry     (w_cell[g])
            );
        end else begin : g_end
            mtt_cell u_cell (
                .i_clk       (i_clk),
                .i_load      (w_load[g]),
                .i_load_data (w_load_data),
                .i_shift     (w_shift),
                .i_neighbor  (w_cell[g]),
                .o_entry     (w_cell[g])
            );
        end
        assign w_load[g] = w_load_en && (w_load_idx == IW'(g));
    end

    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == mtt_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_tail        = r_count - CW'(1);

    // Head entry update for a tick
    assign w_head = w_cell[0];
    assign w_hit  = (w_head.expiry <= r_now);
    always_comb begin
        w_upd = w_head;
        if (w_hit) begin
            w_upd.expiry = mtt_pkg::sat_add(r_now, w_head.period);
            if (w_head.repeats > 16'sd0) begin
                w_upd.repeats = w_head.repeats - 16'sd1;
            end
        end
    end
    assign w_fin  = w_hit && (w_upd.repeats == 16'sd0);
    assign w_diff = w_upd.expiry - r_now;
    assign w_wait = (w_upd.expiry < r_now) ? {1'b0, mtt_pkg::WAIT_MAX} : w_diff;

    // New entry from the request
    always_comb begin
        w_new.id      = s_axis_tdata[7:0];
        w_new.expiry  = mtt_pkg::sat_add(s_axis_tdata[39:8], s_axis_tdata[70:40]);
        w_new.period  = s_axis_tdata[101:71];
        w_new.repeats = s_axis_tdata[117:102];
    end

    // Sequencer: next state, cell controls and results
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_now       = r_now;
        n_count     = r_count;
        n_left      = r_left;
        n_found     = r_found;
        n_best      = r_best;
        n_res       = r_res;
        n_ovalid    = r_ovalid && !m_axis_tready;
        n_out       = r_out;
        w_shift     = 1'b0;
        w_load_en   = 1'b0;
        w_load_idx  = w_tail[IW-1:0];
        w_load_data = w_upd;

        unique case (r_state)
            mtt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op  = s_axis_tuser;
                    n_id  = s_axis_tdata[7:0];
                    n_now = s_axis_tdata[39:8];
                    n_res = '0;
                    n_res.last = 1'b1;
                    unique case (s_axis_tuser)
                        mtt_pkg::OP_ADD: begin
                            n_res.kind = mtt_pkg::KIND_ADD;
                            n_res.id   = s_axis_tdata[7:0];
                            if (r_count == CW'(SLOTS)) begin
                                n_res.status = mtt_pkg::STAT_FULL;
                            end else begin
                                w_load_en   = 1'b1;
                                w_load_idx  = r_count[IW-1:0];
                                w_load_data = w_new;
                                n_count     = r_count + CW'(1);
                            end
                            n_state = mtt_pkg::ST_EMIT;
                        end
                        mtt_pkg::OP_CLEAR: begin
                            n_res.kind = mtt_pkg::KIND_CLEAR;
                            n_count    = '0;
                            n_state    = mtt_pkg::ST_EMIT;
                        end
                        default: begin
                            n_left  = r_count;
                            n_found = 1'b0;
                            n_best  = mtt_pkg::WAIT_MAX;
                            n_state = mtt_pkg::ST_SCAN;
                        end
                    endcase
                end
            end

            mtt_pkg::ST_SCAN: begin
                if (r_left == '0) begin
                    n_res = '0;
                    n_res.last = 1'b1;
                    if (r_op == mtt_pkg::OP_TICK) begin
                        n_res.kind      = mtt_pkg::KIND_TICK;
                        n_res.next_wait = r_best;
                    end else begin
                        n_res.kind   = mtt_pkg::KIND_REMOVE;
                        n_res.id     = r_id;
                        n_res.status = r_found ? mtt_pkg::STAT_OK : mtt_pkg::STAT_NOT_FOUND;
                    end
                    n_state = mtt_pkg::ST_EMIT;
                end else if (r_op == mtt_pkg::OP_TICK) begin
                    // Hold on a due entry until the result register frees
                    if (!w_hit || w_out_free) begin
                        w_shift = 1'b1;
                        n_left  = r_left - CW'(1);
                        if (w_hit) begin
                            n_ovalid = 1'b1;
                            n_out    = '0;
                            n_out.kind     = mtt_pkg::KIND_FIRE;
                            n_out.id       = w_head.id;
                            n_out.finished = w_fin;
                        end
                        if (w_fin) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            w_load_en = 1'b1;
                            if (w_wait < {1'b0, r_best}) begin
                                n_best = w_wait[30:0];
                            end
                        end
                    end
                end else begin
                    // Remove: drop the oldest match, rotate the rest
                    w_shift     = 1'b1;
                    n_left      = r_left - CW'(1);
                    w_load_data = w_head;
                    if (!r_found && (w_head.id == r_id)) begin
                        n_found = 1'b1;
                        n_count = r_count - CW'(1);
                    end else begin
                        w_load_en = 1'b1;
                    end
                end
            end

            mtt_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = r_res;
                    n_state  = mtt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = mtt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mtt_pkg::ST_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_found  <= n_found;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_id   <= n_id;
        r_now  <= n_now;
        r_best <= n_best;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {6'b0, r_out.next_wait, r_out.finished, r_out.status, r_out.id};

endmodule

[rtl/mtt_cell.sv]
// One slot of the timer chain: holds an entry, loads a new one or takes its neighbor's.
// Depends on mtt_pkg.
module mtt_cell (
    input  logic            i_clk,
    input  logic            i_load,
    input  mtt_pkg::t_entry i_load_data,
    input  logic            i_shift,
    input  mtt_pkg::t_entry i_neighbor,
    output mtt_pkg::t_entry o_entry
);

    mtt_pkg::t_entry r_entry;

    // Load wins over shift so the rotated head lands at the tail
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_load_data;
        end else if (i_shift) begin
            r_entry <= i_neighbor;
        end
    end

    assign o_entry = r_entry;

endmodule
